FILE: src/imts_pkg.sv
// ----------------------------------------------------------------------------
// imts_pkg
// Shared types and constants of the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package imts_pkg;

  typedef enum logic [1:0] {
    OP_POLL     = 2'd0,
    OP_LOAD     = 2'd1,
    OP_BEGIN_WR = 2'd2,
    OP_BEGIN_RD = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_SEND     = 3'd3,
    CMD_SEND_ACK = 3'd4
  } cmd_e;

  localparam logic [7:0] ST_MASK     = 8'hF8;
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_SLAW_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK = 8'h40;

  localparam logic [8:0] POS_MAX = 9'h1FF;

  typedef struct packed {
    opcode_e    opcode;
    logic [4:0] slot;
    logic [7:0] data_byte;
    logic [7:0] count;
    logic       bus_ready;
    logic [7:0] bus_status;
    logic [7:0] bus_rx_byte;
  } item_t;

  typedef struct packed {
    cmd_e       bus_command;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_index;
    logic [7:0] read_byte;
    logic       idle;
    logic [7:0] error_code;
  } result_t;

endpackage

FILE: src/imts_if.sv
// ----------------------------------------------------------------------------
// imts_if
// Valid/ready channels for sequencer items and results.
// ----------------------------------------------------------------------------
interface imts_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [4:0] slot;
  logic [7:0] data_byte;
  logic [7:0] count;
  logic       bus_ready;
  logic [7:0] bus_status;
  logic [7:0] bus_rx_byte;

  modport source (
    output valid, opcode, slot, data_byte, count, bus_ready, bus_status, bus_rx_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot, data_byte, count, bus_ready, bus_status, bus_rx_byte,
    output ready
  );
endinterface

interface imts_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_command;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       read_valid;
  logic [7:0] read_index;
  logic [7:0] read_byte;
  logic       idle;
  logic [7:0] error_code;

  modport source (
    output valid, bus_command, tx_valid, tx_byte, read_valid, read_index, read_byte,
    output idle, error_code,
    input  ready
  );
  modport sink (
    input  valid, bus_command, tx_valid, tx_byte, read_valid, read_index, read_byte,
    input  idle, error_code,
    output ready
  );
endinterface

FILE: src/imts_ram.sv
// ----------------------------------------------------------------------------
// imts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/imts_seq_core.sv
// ----------------------------------------------------------------------------
// imts_seq_core
// Sequencer state, write store and the per-item step logic.
// ----------------------------------------------------------------------------
module imts_seq_core #(
  parameter int unsigned WRITE_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  imts_pkg::item_t   item_i,
  input  logic              rd_en_i,
  output imts_pkg::result_t result_o
);

  localparam int unsigned AW      = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam logic [7:0]  DEPTH_B = 8'(WRITE_DEPTH);

  logic [7:0] write_total_q, write_total_d;
  logic [8:0] write_pos_q, write_pos_d;
  logic [7:0] read_total_q, read_total_d;
  logic [7:0] read_pos_q, read_pos_d;
  logic [7:0] error_q, error_d;
  logic       started_q, started_d;
  logic [7:0] read_addr_q, read_addr_d;
  logic       read_mode_q, read_mode_d;

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;
  logic [7:0]    store_byte;
  logic          byp_valid_q;
  logic [7:0]    byp_data_q;
  logic [8:0]    rd_pos;

  logic [7:0]     status;
  logic [7:0]     want;
  imts_pkg::cmd_e cmd;
  logic           tx_v;
  logic [7:0]     tx_b;
  logic           rd_v;
  logic [7:0]     rd_i;
  logic [7:0]     rd_b;
  logic           idle;

  assign st_waddr = AW'(item_i.slot);
  assign rd_pos   = fire_i ? write_pos_d : write_pos_q;
  assign st_raddr = rd_pos[AW-1:0];

  imts_ram #(
    .WIDTH (8),
    .DEPTH (WRITE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (item_i.data_byte),
    .re_i    (rd_en_i),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // forward a store write that lands on the address being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_valid_q <= st_we && (st_waddr == st_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_data_q <= item_i.data_byte;
    end
  end

  assign store_byte = byp_valid_q ? byp_data_q : st_rdata;

  always_comb begin
    status        = item_i.bus_status & imts_pkg::ST_MASK;
    want          = imts_pkg::ST_DATA_ACK;
    cmd           = imts_pkg::CMD_NONE;
    tx_v          = 1'b0;
    tx_b          = 8'd0;
    rd_v          = 1'b0;
    rd_i          = 8'd0;
    rd_b          = 8'd0;
    st_we         = 1'b0;
    write_total_d = write_total_q;
    write_pos_d   = write_pos_q;
    read_total_d  = read_total_q;
    read_pos_d    = read_pos_q;
    error_d       = error_q;
    started_d     = started_q;
    read_addr_d   = read_addr_q;
    read_mode_d   = read_mode_q;

    unique case (item_i.opcode)
      imts_pkg::OP_LOAD: begin
        st_we = fire_i && (32'(item_i.slot) < WRITE_DEPTH);
      end
      imts_pkg::OP_BEGIN_WR: begin
        write_total_d = (item_i.count > DEPTH_B) ? DEPTH_B : item_i.count;
        write_pos_d   = 9'd0;
        read_total_d  = 8'd0;
        read_pos_d    = 8'd0;
        error_d       = 8'd0;
        started_d     = 1'b0;
        read_mode_d   = 1'b0;
      end
      imts_pkg::OP_BEGIN_RD: begin
        read_addr_d   = item_i.data_byte;
        write_total_d = 8'd1;
        write_pos_d   = 9'd0;
        read_total_d  = item_i.count;
        read_pos_d    = 8'd0;
        error_d       = 8'd0;
        started_d     = 1'b0;
        read_mode_d   = 1'b1;
      end
      imts_pkg::OP_POLL: begin
        if (write_pos_q == 9'd0 && read_pos_q == 8'd0 && write_total_q != 8'd0 &&
            error_q == 8'd0 && !started_q) begin
          cmd       = imts_pkg::CMD_START;
          started_d = 1'b1;
        end else if (item_i.bus_ready) begin
          if (write_pos_q < {1'b0, write_total_q}) begin
            priority if (write_pos_q == 9'd0) begin
              want = imts_pkg::ST_START;
            end else if (write_pos_q == 9'd1) begin
              want = imts_pkg::ST_SLAW_ACK;
            end else begin
              want = imts_pkg::ST_DATA_ACK;
            end
            if (status != want) begin
              error_d   = status | 8'h01;
              cmd       = imts_pkg::CMD_STOP;
              started_d = 1'b0;
            end
            if (error_d == 8'd0) begin
              tx_v        = 1'b1;
              tx_b        = read_mode_q ? read_addr_q : store_byte;
              write_pos_d = write_pos_q + 9'd1;
              cmd         = imts_pkg::CMD_SEND;
            end
          end else if (read_pos_q < read_total_q) begin
            if (write_pos_q == 9'd1 && status != imts_pkg::ST_SLAR_ACK) begin
              error_d   = status | 8'h01;
              cmd       = imts_pkg::CMD_STOP;
              started_d = 1'b0;
            end
            if (error_d == 8'd0) begin
              if (write_pos_q != imts_pkg::POS_MAX) begin
                write_pos_d = write_pos_q + 9'd1;
              end
              if (write_pos_q > 9'd1) begin
                rd_v       = 1'b1;
                rd_i       = read_pos_q;
                rd_b       = item_i.bus_rx_byte;
                read_pos_d = read_pos_q + 8'd1;
              end
              if (({1'b0, read_pos_d} + 9'd1) < {1'b0, read_total_q}) begin
                cmd = imts_pkg::CMD_SEND_ACK;
              end else if (read_pos_d < read_total_q) begin
                cmd = imts_pkg::CMD_SEND;
              end
            end
          end else if (started_q) begin
            cmd       = imts_pkg::CMD_STOP;
            started_d = 1'b0;
          end
        end
      end
    endcase

    idle = (write_pos_d >= {1'b0, write_total_d}) && (read_pos_d == read_total_d) &&
           !started_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_total_q <= 8'd0;
      write_pos_q   <= 9'd0;
      read_total_q  <= 8'd0;
      read_pos_q    <= 8'd0;
      error_q       <= 8'd0;
      started_q     <= 1'b0;
      read_addr_q   <= 8'd0;
      read_mode_q   <= 1'b0;
    end else if (fire_i) begin
      write_total_q <= write_total_d;
      write_pos_q   <= write_pos_d;
      read_total_q  <= read_total_d;
      read_pos_q    <= read_pos_d;
      error_q       <= error_d;
      started_q     <= started_d;
      read_addr_q   <= read_addr_d;
      read_mode_q   <= read_mode_d;
    end
  end

  assign result_o = '{
    bus_command: cmd,
    tx_valid:    tx_v,
    tx_byte:     tx_b,
    read_valid:  rd_v,
    read_index:  rd_i,
    read_byte:   rd_b,
    idle:        idle,
    error_code:  error_d
  };

endmodule

FILE: src/i2c_master_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Steps an I2C master peripheral through one write or read transaction.
// ----------------------------------------------------------------------------
//   channel    role    handshake      beat
//   item_i     sink    valid/ready    opcode, slot, data_byte, count, bus flags
//   result_o   source  valid/ready    bus command, tx/read bytes, idle, error
//
// One item per cycle sustained while result_o does not stall; an item beat
// reaches result_o.valid through the input register and the result register.
// An input register feeds the step logic, which writes the result register.
// item_i.ready drops only while both registers are full and result_o stalls.
// Reset clears both valid flags and the sequencer state; the write store holds
// no defined content until loaded.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
  parameter int unsigned WRITE_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  imts_item_if.sink    item_i,
  imts_result_if.source result_o
);

  logic              in_accept;
  logic              s1_fire;
  logic              s1_valid_q, s1_valid_d;
  imts_pkg::item_t   in_item;
  imts_pkg::item_t   s1_item_q;
  logic              out_valid_q, out_valid_d;
  imts_pkg::result_t core_result;
  imts_pkg::result_t out_q;

  assign s1_fire      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || s1_fire;
  assign in_accept    = item_i.valid && item_i.ready;

  always_comb begin
    in_item.opcode      = imts_pkg::opcode_e'(item_i.opcode);
    in_item.slot        = item_i.slot;
    in_item.data_byte   = item_i.data_byte;
    in_item.count       = item_i.count;
    in_item.bus_ready   = item_i.bus_ready;
    in_item.bus_status  = item_i.bus_status;
    in_item.bus_rx_byte = item_i.bus_rx_byte;
  end

  always_comb begin
    s1_valid_d  = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    out_valid_d = s1_fire ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item;
    end
    if (s1_fire) begin
      out_q <= core_result;
    end
  end

  imts_seq_core #(
    .WRITE_DEPTH (WRITE_DEPTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .item_i   (s1_item_q),
    .rd_en_i  (in_accept),
    .result_o (core_result)
  );

  assign result_o.valid       = out_valid_q;
  assign result_o.bus_command = out_q.bus_command;
  assign result_o.tx_valid    = out_q.tx_valid;
  assign result_o.tx_byte     = out_q.tx_byte;
  assign result_o.read_valid  = out_q.read_valid;
  assign result_o.read_index  = out_q.read_index;
  assign result_o.read_byte   = out_q.read_byte;
  assign result_o.idle        = out_q.idle;
  assign result_o.error_code  = out_q.error_code;

endmodule

FILE: src/imts_checker.sv
// ----------------------------------------------------------------------------
// imts_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module imts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_cmd_i,
  input logic       out_tx_valid_i,
  input logic       out_idle_i,
  input logic [7:0] out_error_i
);

  // input backs up only behind a stalled result
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("item channel stalled while result channel free");

  // a fresh result follows an item beat through the input and result registers
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without a matching item beat");

  // start leaves the bus busy and error free
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_cmd_i == imts_pkg::CMD_START) |-> (!out_idle_i && out_error_i == 8'd0))
    else $error("start issued while idle or in error");

  // hold a stalled result
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_cmd_i) && $stable(out_tx_valid_i) && $stable(out_error_i)))
    else $error("stalled result changed");

endmodule

bind i2c_master_transaction_sequencer imts_checker u_imts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .out_cmd_i      (result_o.bus_command),
  .out_tx_valid_i (result_o.tx_valid),
  .out_idle_i     (result_o.idle),
  .out_error_i    (result_o.error_code)
);

FILE: verif/i2c_master_transaction_sequencer_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_tb
// Self-checking bench: feeds load, begin and poll beats under random gaps and
// result stalls, predicts every result beat with a cycle-free model of the
// sequencer and compares each field in order of arrival.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_tb;
  import imts_pkg::*;

  localparam int STORE_DEPTH = 32;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_LIMIT = 1000;
  localparam int REPORT_LIMIT = 40;

  logic clk_i;
  logic rst_ni;

  imts_item_if   item_if ();
  imts_result_if res_if ();

  i2c_master_transaction_sequencer #(
    .WRITE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if)
  );

  item_t   item_backlog[$];
  result_t bus_outcomes[$];

  int  items_queued = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  bytes_read = 0;
  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  write_begins = 0;
  int  read_begins = 0;
  int  status_aborts = 0;
  bit  slot_loaded[STORE_DEPTH];

  bit       item_beat = 1'b0;
  bit       res_beat = 1'b0;
  bit       item_calm = 1'b0;
  bit       res_calm = 1'b0;
  int       item_hold = 0;
  int       res_hold = 0;

  // sequencer model state
  logic [7:0] wstore[STORE_DEPTH];
  logic [7:0] wr_total;
  logic [8:0] wr_pos;
  logic [7:0] rd_total;
  logic [7:0] rd_pos;
  logic [7:0] err_code;
  logic       bus_held;
  logic [7:0] rd_addr;
  logic       rd_mode;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic arm_transfer(logic [7:0] wtot, logic [7:0] rtot, logic rd);
    wr_total = wtot;
    wr_pos   = '0;
    rd_total = rtot;
    rd_pos   = '0;
    err_code = '0;
    bus_held = 1'b0;
    rd_mode  = rd;
  endtask

  task automatic match_status(logic [7:0] st, logic [7:0] want, inout cmd_e cmd);
    if (st != want) begin
      err_code = st | 8'h01;
      cmd = CMD_STOP;
      bus_held = 1'b0;
      status_aborts++;
    end
  endtask

  task automatic step_bus_sequencer(input item_t it, output result_t r);
    logic [7:0] st;
    logic [8:0] prev;
    cmd_e       cmd;
    st  = it.bus_status & ST_MASK;
    r   = '0;
    cmd = CMD_NONE;
    case (it.opcode)
      OP_LOAD: begin
        if (it.slot < STORE_DEPTH) wstore[it.slot] = it.data_byte;
      end
      OP_BEGIN_WR: begin
        write_begins++;
        arm_transfer(it.count > STORE_DEPTH ? 8'(STORE_DEPTH) : it.count, 8'd0, 1'b0);
      end
      OP_BEGIN_RD: begin
        read_begins++;
        rd_addr = it.data_byte;
        arm_transfer(8'd1, it.count, 1'b1);
      end
      default: begin
        if (wr_pos == 0 && rd_pos == 0 && wr_total != 0 && err_code == 0 && !bus_held) begin
          cmd = CMD_START;
          bus_held = 1'b1;
        end else if (it.bus_ready) begin
          if (wr_pos < wr_total) begin
            match_status(st, wr_pos == 0 ? ST_START :
                             (wr_pos == 1 ? ST_SLAW_ACK : ST_DATA_ACK), cmd);
            if (err_code == 0) begin
              if (rd_mode) r.tx_byte = rd_addr;
              else if (wr_pos < STORE_DEPTH) r.tx_byte = wstore[wr_pos[4:0]];
              r.tx_valid = 1'b1;
              wr_pos = wr_pos + 9'd1;
              cmd = CMD_SEND;
            end
          end else if (rd_pos < rd_total) begin
            if (wr_pos == 1) match_status(st, ST_SLAR_ACK, cmd);
            if (err_code == 0) begin
              prev = wr_pos;
              if (wr_pos < POS_MAX) wr_pos = wr_pos + 9'd1;
              if (prev > 1) begin
                r.read_valid = 1'b1;
                r.read_index = rd_pos;
                r.read_byte  = it.bus_rx_byte;
                rd_pos = rd_pos + 8'd1;
              end
              if (int'(rd_pos) + 1 < int'(rd_total)) cmd = CMD_SEND_ACK;
              else if (rd_pos < rd_total) cmd = CMD_SEND;
            end
          end else if (bus_held) begin
            cmd = CMD_STOP;
            bus_held = 1'b0;
          end
        end
      end
    endcase
    r.bus_command = cmd;
    r.idle = (wr_pos >= wr_total) && (rd_pos == rd_total) && !bus_held;
    r.error_code = err_code;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // drive item beats
  always @(negedge clk_i) begin : drive_items
    item_t nxt;
    if (rst_ni && (!item_if.valid || item_beat)) begin
      if (item_hold != 0) begin
        item_if.valid <= 1'b0;
        item_hold <= item_hold - 1;
      end else if (item_backlog.size() != 0) begin
        nxt = item_backlog.pop_front();
        if ($urandom_range(0, 39) == 0) item_calm = !item_calm;
        item_if.valid       <= 1'b1;
        item_if.opcode      <= nxt.opcode;
        item_if.slot        <= nxt.slot;
        item_if.data_byte   <= nxt.data_byte;
        item_if.count       <= nxt.count;
        item_if.bus_ready   <= nxt.bus_ready;
        item_if.bus_status  <= nxt.bus_status;
        item_if.bus_rx_byte <= nxt.bus_rx_byte;
        item_hold <= draw_gap(item_calm);
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // stall result beats
  always @(negedge clk_i) begin : stall_results
    int next_hold;
    if (rst_ni) begin
      if (res_beat) begin
        if ($urandom_range(0, 39) == 0) res_calm = !res_calm;
        next_hold = draw_gap(res_calm);
      end else begin
        next_hold = (res_hold != 0) ? res_hold - 1 : 0;
      end
      res_hold <= next_hold;
      res_if.ready <= (next_hold == 0);
    end
  end

  always @(posedge clk_i) begin : watch_ports
    item_t   it;
    result_t pred;
    result_t want;
    result_t got;
    if (rst_ni) begin
      item_beat <= item_if.valid && item_if.ready;
      res_beat  <= res_if.valid && res_if.ready;
      if (item_if.valid && item_if.ready) begin
        it.opcode      = opcode_e'(item_if.opcode);
        it.slot        = item_if.slot;
        it.data_byte   = item_if.data_byte;
        it.count       = item_if.count;
        it.bus_ready   = item_if.bus_ready;
        it.bus_status  = item_if.bus_status;
        it.bus_rx_byte = item_if.bus_rx_byte;
        step_bus_sequencer(it, pred);
        bus_outcomes.push_back(pred);
        items_sent++;
      end
      if (res_if.valid && res_if.ready) begin
        got.bus_command = cmd_e'(res_if.bus_command);
        got.tx_valid    = res_if.tx_valid;
        got.tx_byte     = res_if.tx_byte;
        got.read_valid  = res_if.read_valid;
        got.read_index  = res_if.read_index;
        got.read_byte   = res_if.read_byte;
        got.idle        = res_if.idle;
        got.error_code  = res_if.error_code;
        results_seen++;
        if (got.read_valid === 1'b1) bytes_read++;
        if (bus_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with none expected, got command %0d", $time,
                   res_if.bus_command);
        end else begin
          want = bus_outcomes.pop_front();
          check_field("bus_command", want.bus_command, got.bus_command);
          check_field("tx_valid", want.tx_valid, got.tx_valid);
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("read_valid", want.read_valid, got.read_valid);
          check_field("read_index", want.read_index, got.read_index);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("idle", want.idle, got.idle);
          check_field("error_code", want.error_code, got.error_code);
        end
      end
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                   quiet_cycles, bus_outcomes.size());
          $display("FAIL i2c_master_transaction_sequencer");
          $finish;
        end
      end
    end
  end

  task automatic queue_item(opcode_e op, logic [4:0] slot, logic [7:0] dbyte,
                            logic [7:0] cnt, logic rdy, logic [7:0] st, logic [7:0] rx);
    item_t it;
    it.opcode      = op;
    it.slot        = slot;
    it.data_byte   = dbyte;
    it.count       = cnt;
    it.bus_ready   = rdy;
    it.bus_status  = st;
    it.bus_rx_byte = rx;
    item_backlog.push_back(it);
    items_queued++;
    if (op == OP_LOAD) slot_loaded[slot] = 1'b1;
  endtask

  task automatic queue_poll(logic rdy, logic [7:0] st);
    queue_item(OP_POLL, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), rdy, st, 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_load(logic [4:0] slot, logic [7:0] dbyte);
    queue_item(OP_LOAD, slot, dbyte, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] status_for(logic [7:0] want, bit wrong);
    logic [7:0] st;
    st = want | 8'($urandom_range(0, 7));
    if (wrong) begin
      do st = 8'($urandom_range(0, 255)); while ((st & ST_MASK) == want);
    end
    return st;
  endfunction

  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < STORE_DEPTH && slot_loaded[n]) n++;
    return n;
  endfunction

  // begin a transfer, then poll it through; a broken one stops early
  task automatic queue_transfer(bit rd, int n, logic [7:0] addr, bit broken);
    int         eff;
    int         polls;
    int         upto;
    bit         checked;
    logic [7:0] want;
    eff = (n > STORE_DEPTH) ? STORE_DEPTH : n;
    if (rd) begin
      queue_item(OP_BEGIN_RD, 5'($urandom_range(0, 31)), addr, 8'(n), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      polls = n + 3;
    end else begin
      for (int k = 0; k < eff; k++)
        if (!slot_loaded[k]) queue_load(5'(k), 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2))
        queue_load(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
      queue_item(OP_BEGIN_WR, 5'($urandom_range(0, 31)), addr, 8'(n), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      polls = eff + 1;
    end
    upto = broken ? $urandom_range(0, polls) : polls;
    queue_poll(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    for (int k = 0; k < upto; k++) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) queue_poll(1'b0, 8'($urandom_range(0, 255)));
      checked = rd ? (k < 2) : (k < eff);
      want = (k == 0) ? ST_START : ((k == 1) ? (rd ? ST_SLAR_ACK : ST_SLAW_ACK) : ST_DATA_ACK);
      queue_poll(1'b1, checked ? status_for(want, $urandom_range(0, 29) == 0)
                               : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_noise();
    opcode_e op;
    int      lim;
    repeat ($urandom_range(1, 4)) begin
      op = opcode_e'($urandom_range(0, 3));
      lim = loaded_prefix();
      if (op == OP_BEGIN_WR && lim < STORE_DEPTH)
        queue_item(op, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, lim)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
        queue_item(op, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  function automatic int draw_write_count();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom_range(33, 255);
    if (pick < 4) return $urandom_range(9, 32);
    return $urandom_range(1, 8);
  endfunction

  function automatic int draw_read_count();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick == 0) return $urandom_range(0, 255);
    if (pick == 1) return 0;
    return $urandom_range(1, 6);
  endfunction

  task automatic wait_drained();
    while (items_sent != items_queued || bus_outcomes.size() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int  random_start;
    int  pick;
    bit  paused;
    item_if.valid       = 1'b0;
    item_if.opcode      = '0;
    item_if.slot        = '0;
    item_if.data_byte   = '0;
    item_if.count       = '0;
    item_if.bus_ready   = 1'b0;
    item_if.bus_status  = '0;
    item_if.bus_rx_byte = '0;
    res_if.ready        = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: store extremes, short write, empty write, read, status aborts
    queue_load(5'd0, 8'h00);
    queue_load(5'd1, 8'hFF);
    queue_load(5'd31, 8'hA5);
    queue_transfer(1'b0, 2, 8'h00, 1'b0);
    queue_transfer(1'b0, 0, 8'hFF, 1'b0);
    queue_transfer(1'b1, 1, 8'hFF, 1'b0);
    queue_item(OP_BEGIN_RD, 5'd31, 8'h00, 8'd2, 1'b0, 8'h00, 8'h00);
    queue_poll(1'b0, 8'h00);
    queue_poll(1'b1, 8'h20);
    queue_poll(1'b1, 8'h0F);
    queue_poll(1'b1, 8'hFF);
    queue_item(OP_BEGIN_WR, 5'd0, 8'h00, 8'd1, 1'b1, 8'h08, 8'hFF);
    queue_poll(1'b1, 8'h08);
    wait_drained();

    random_start = items_queued;
    paused = 1'b0;
    for (int k = 0; k < STORE_DEPTH; k++) queue_load(5'(k), 8'($urandom_range(0, 255)));
    queue_transfer(1'b0, 255, 8'($urandom_range(0, 255)), 1'b0);
    while (items_queued - random_start < RANDOM_ITEMS) begin
      if (!paused && items_queued - random_start >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45)
        queue_transfer(1'b0, draw_write_count(), 8'($urandom_range(0, 255)),
                       $urandom_range(0, 9) == 0);
      else if (pick < 85)
        queue_transfer(1'b1, draw_read_count(), 8'($urandom_range(0, 255)),
                       $urandom_range(0, 9) == 0);
      else
        queue_noise();
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    $display("Sent %0d beats (%0d write and %0d read begins), checked %0d results,",
             items_sent, write_begins, read_begins, results_seen);
    $display("  %0d bytes read back, %0d status aborts, %0d mismatches.",
             bytes_read, status_aborts, fail_count);
    if (fail_count == 0) begin
      $display("PASS i2c_master_transaction_sequencer");
    end else begin
      $display("FAIL i2c_master_transaction_sequencer");
    end
    $finish;
  end

endmodule

FILE: files.f
src/imts_pkg.sv
src/imts_if.sv
src/imts_ram.sv
src/imts_seq_core.sv
src/i2c_master_transaction_sequencer.sv
src/imts_checker.sv
verif/i2c_master_transaction_sequencer_tb.sv
